### design/tcw_pkg.sv
// Shared types and constants for the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

  typedef logic [1:0]  action_t;
  typedef logic [7:0]  byte_t;
  typedef logic [15:0] cell_t;

  localparam action_t ACT_PUT   = 2'd0;
  localparam action_t ACT_READ  = 2'd1;
  localparam action_t ACT_CLEAR = 2'd2;

  localparam byte_t NEWLINE_CODE = 8'd10;
  localparam byte_t BLANK_CODE   = 8'd32;
  localparam byte_t RESET_ATTR   = 8'd7;
  localparam cell_t RESET_CELL   = {RESET_ATTR, BLANK_CODE};

  localparam int unsigned CELL_W     = 16;
  localparam int unsigned ROW_OUT_W  = 5;
  localparam int unsigned COL_OUT_W  = 7;
  localparam int unsigned RD_ADDR_W  = 11;

endpackage

### design/tcw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/text_console_writer_unit.sv
// Top level of the text console writer: cell memory, cursor and sequencer.
`timescale 1ns / 1ps

// Character-cell text console of ROWS x COLUMNS 16-bit cells (attribute in the
// high byte, character in the low byte) with a cursor. Each input transaction
// carries an action in in_tuser: put a character at the cursor (10 is newline),
// read one cell, or clear the screen and home the cursor; each produces exactly
// one result transaction with the read data and the cursor after the action.
// The block handles one transaction at a time and all cell traffic goes through
// the single write port and single read port of one cell memory. A put that
// moves the cursor past the last row scrolls the screen: it copies
// ROWS*COLUMNS-COLUMNS cells one per cycle, then blanks the bottom row one cell
// per cycle. A clear writes every cell once. After reset the block runs a
// clearing pass over every cell before in_tready rises; configuration writes
// are accepted throughout.
module text_console_writer_unit
  import tcw_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  action_t     in_tuser,   // [1:0] action
  input  logic [23:0] in_tdata,   // [7:0] char_code, [18:8] read_address, zero above
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] read_data, [20:16] cursor_row,
                                  // [27:21] cursor_col, zero above
  // Attribute register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // [7:0] text_attribute
);

  localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
  localparam int unsigned AW = $clog2(CELL_COUNT);
  localparam int unsigned RW = $clog2(ROWS);
  localparam int unsigned CW = $clog2(COLUMNS);

  localparam logic [AW-1:0] LAST_CELL   = AW'(CELL_COUNT - 1);
  localparam logic [AW-1:0] COLS_A      = AW'(COLUMNS);
  localparam logic [AW-1:0] BOTTOM_BASE = AW'(CELL_COUNT - COLUMNS);
  localparam logic [CW-1:0] COL_LAST    = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST    = RW'(ROWS - 1);

  localparam logic [3:0] S_INIT     = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_PUT      = 4'd2;
  localparam logic [3:0] S_READ     = 4'd3;
  localparam logic [3:0] S_CLEAR    = 4'd4;
  localparam logic [3:0] S_COPY     = 4'd5;
  localparam logic [3:0] S_COPY_END = 4'd6;
  localparam logic [3:0] S_BLANK    = 4'd7;
  localparam logic [3:0] S_FINISH   = 4'd8;

  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [AW-1:0] row_base_r, row_base_nxt;
  logic [AW-1:0] cur_addr_r, cur_addr_nxt;
  byte_t         attr_r, attr_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          cp_valid_r, cp_valid_nxt;

  byte_t         char_r, char_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  cell_t         res_data_r, res_data_nxt;
  logic [AW-1:0] cp_dst_r, cp_dst_nxt;
  logic [31:0]   out_data_r, out_data_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  cell_t         ram_wdata;
  logic [AW-1:0] ram_raddr;
  cell_t         ram_rdata;

  logic          in_accept;
  logic          fin;
  cell_t         fin_data;
  logic          out_free;
  logic          col_wrap;
  byte_t         in_char;
  logic [31:0]   in_addr_ext;
  logic [31:0]   row_ext;
  logic [31:0]   col_ext;
  cell_t         blank_cell;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_tready   = (state_r == S_IDLE);
  assign in_accept   = in_tvalid && in_tready;
  assign cfg_ready   = 1'b1;
  assign out_tvalid  = out_valid_r;
  assign out_tdata   = out_data_r;
  assign out_free    = !out_valid_r || out_tready;
  assign in_char     = in_tdata[7:0];
  assign in_addr_ext = 32'(in_tdata[18:8]);
  assign blank_cell  = {attr_r, BLANK_CODE};
  assign col_wrap    = (char_r == NEWLINE_CODE) || (col_r == COL_LAST);
  assign row_ext     = 32'(row_nxt);
  assign col_ext     = 32'(col_nxt);

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    row_base_nxt  = row_base_r;
    cur_addr_nxt  = cur_addr_r;
    attr_nxt      = attr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cp_valid_nxt  = cp_valid_r;
    char_nxt      = char_r;
    rd_ok_nxt     = rd_ok_r;
    res_data_nxt  = res_data_r;
    cp_dst_nxt    = cp_dst_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = ptr_r;
    ram_wdata     = blank_cell;
    ram_raddr     = in_addr_ext[AW-1:0];
    fin           = 1'b0;
    fin_data      = '0;

    if (cfg_valid) begin
      attr_nxt = cfg_data;
    end

    case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = RESET_CELL;
        ptr_nxt   = ptr_r + 1'b1;
        if (ptr_r == LAST_CELL) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          case (in_tuser)
            ACT_PUT: begin
              char_nxt  = in_char;
              state_nxt = S_PUT;
            end
            ACT_READ: begin
              rd_ok_nxt = (in_addr_ext < CELL_COUNT);
              state_nxt = S_READ;
            end
            ACT_CLEAR: begin
              ptr_nxt      = '0;
              row_nxt      = '0;
              col_nxt      = '0;
              row_base_nxt = '0;
              cur_addr_nxt = '0;
              state_nxt    = S_CLEAR;
            end
            default: begin
              res_data_nxt = '0;
              state_nxt    = S_FINISH;
            end
          endcase
        end
      end
      S_PUT: begin
        if (char_r != NEWLINE_CODE) begin
          ram_we    = 1'b1;
          ram_waddr = cur_addr_r;
          ram_wdata = {attr_r, char_r};
        end
        if (!col_wrap) begin
          col_nxt      = col_r + 1'b1;
          cur_addr_nxt = cur_addr_r + 1'b1;
          fin          = 1'b1;
        end else begin
          col_nxt = '0;
          if (row_r == ROW_LAST) begin
            // Bottom row stays the cursor row; the screen moves up under it.
            cur_addr_nxt = row_base_r;
            ptr_nxt      = COLS_A;
            cp_valid_nxt = 1'b0;
            state_nxt    = S_COPY;
          end else begin
            row_nxt      = row_r + 1'b1;
            row_base_nxt = row_base_r + COLS_A;
            cur_addr_nxt = row_base_r + COLS_A;
            fin          = 1'b1;
          end
        end
      end
      S_READ: begin
        fin      = 1'b1;
        fin_data = rd_ok_r ? ram_rdata : '0;
      end
      S_CLEAR: begin
        ram_we  = 1'b1;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == LAST_CELL) begin
          fin = 1'b1;
        end
      end
      S_COPY: begin
        // Read one row ahead; the cell read last cycle is written this cycle.
        ram_raddr    = ptr_r;
        cp_valid_nxt = 1'b1;
        cp_dst_nxt   = ptr_r - COLS_A;
        if (cp_valid_r) begin
          ram_we    = 1'b1;
          ram_waddr = cp_dst_r;
          ram_wdata = ram_rdata;
        end
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == LAST_CELL) begin
          state_nxt = S_COPY_END;
        end
      end
      S_COPY_END: begin
        ram_we       = 1'b1;
        ram_waddr    = cp_dst_r;
        ram_wdata    = ram_rdata;
        cp_valid_nxt = 1'b0;
        ptr_nxt      = BOTTOM_BASE;
        state_nxt    = S_BLANK;
      end
      S_BLANK: begin
        ram_we  = 1'b1;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == LAST_CELL) begin
          fin = 1'b1;
        end
      end
      S_FINISH: begin
        fin      = 1'b1;
        fin_data = res_data_r;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = {4'd0, col_ext[COL_OUT_W-1:0], row_ext[ROW_OUT_W-1:0], fin_data};
        state_nxt     = S_IDLE;
      end else begin
        res_data_nxt = fin_data;
        state_nxt    = S_FINISH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      ptr_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      row_base_r  <= '0;
      cur_addr_r  <= '0;
      attr_r      <= RESET_ATTR;
      out_valid_r <= 1'b0;
      cp_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      row_base_r  <= row_base_nxt;
      cur_addr_r  <= cur_addr_nxt;
      attr_r      <= attr_nxt;
      out_valid_r <= out_valid_nxt;
      cp_valid_r  <= cp_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r     <= char_nxt;
    rd_ok_r    <= rd_ok_nxt;
    res_data_r <= res_data_nxt;
    cp_dst_r   <= cp_dst_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  // The linear cursor address always matches the row start plus the column.
  a_cursor_addr: assert property (@(posedge clk) disable iff (!rst_n)
    cur_addr_r == row_base_r + AW'(col_r))
    else $error("cursor address out of step with row and column");

  a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r <= ROW_LAST) && (col_r <= COL_LAST))
    else $error("cursor outside the screen");

  // Scroll copies never land in the bottom row, which is blanked afterwards.
  a_copy_dst: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && (state_r == S_COPY || state_r == S_COPY_END) |-> ram_waddr < BOTTOM_BASE)
    else $error("scroll copy wrote into the bottom row");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_tready)
    else $error("new transaction taken while one is in progress");
`endif

endmodule

### verif/text_console_writer_unit_tb.sv
// Self-checking testbench for the text console writer: cell grid, cursor, scroll and clear.
`timescale 1ns / 1ps

module text_console_writer_unit_tb;
  import tcw_pkg::*;

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLS * ROWS;
  localparam action_t ACT_SPARE = 2'd3;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 322;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 600;

  // Result word as it appears on out_tdata, highest bits first.
  typedef struct packed {
    logic [3:0] pad;
    logic [6:0] col;
    logic [4:0] row;
    cell_t      data;
  } console_result_t;

  class console_scoreboard;
    cell_t screen [CELLS];
    int row;
    int col;
    byte_t attr;
    console_result_t pending [$];
    int errors, checked, puts, newlines, reads, clears, spares, scrolls, attr_writes;

    function new();
      foreach (screen[k]) screen[k] = RESET_CELL;
      row = 0;
      col = 0;
      attr = RESET_ATTR;
    endfunction

    function cell_t blank_cell();
      return {attr, BLANK_CODE};
    endfunction

    function void put_char(byte_t code);
      if (code == NEWLINE_CODE) begin
        newlines++;
        row++;
        col = 0;
      end else begin
        screen[row * COLS + col] = {attr, code};
        col++;
      end
      if (col >= COLS) begin
        col = 0;
        row++;
      end
      // Past the last row: shift every row up and blank the bottom one.
      if (row >= ROWS) begin
        scrolls++;
        for (int k = 0; k < CELLS - COLS; k++) screen[k] = screen[k + COLS];
        for (int k = CELLS - COLS; k < CELLS; k++) screen[k] = blank_cell();
        row = ROWS - 1;
      end
    endfunction

    function void note_item(action_t act, byte_t code, logic [RD_ADDR_W-1:0] addr);
      console_result_t want;
      want = '0;
      case (act)
        ACT_PUT: begin
          puts++;
          put_char(code);
        end
        ACT_READ: begin
          reads++;
          if (addr < CELLS) want.data = screen[addr];
        end
        ACT_CLEAR: begin
          clears++;
          foreach (screen[k]) screen[k] = blank_cell();
          row = 0;
          col = 0;
        end
        default: spares++;
      endcase
      want.row = row[4:0];
      want.col = col[6:0];
      pending.push_back(want);
    endfunction

    function void check_result(console_result_t got);
      console_result_t want;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = pending.pop_front();
      if (got.data !== want.data) begin
        errors++;
        $display("%0t: read_data expected %h actual %h", $time, want.data, got.data);
      end
      if (got.row !== want.row) begin
        errors++;
        $display("%0t: cursor_row expected %0d actual %0d", $time, want.row, got.row);
      end
      if (got.col !== want.col) begin
        errors++;
        $display("%0t: cursor_col expected %0d actual %0d", $time, want.col, got.col);
      end
      if (got.pad !== want.pad) begin
        errors++;
        $display("%0t: padding bits expected %h actual %h", $time, want.pad, got.pad);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  action_t     in_tuser;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  console_scoreboard sb;
  bit calm;
  int line_left;
  int idle_cycles = 0;

  text_console_writer_unit #(.COLUMNS(COLS), .ROWS(ROWS)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic send_item(action_t act, byte_t code, logic [RD_ADDR_W-1:0] addr);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 9) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {5'd0, addr, code};
    do @(posedge clk); while (!in_tready);
    sb.note_item(act, code, addr);
  endtask

  task automatic write_attribute(byte_t value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.attr = value;
    sb.attr_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int line_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return $urandom_range(0, 40);
    else if (pick < 85) return $urandom_range(41, 80);
    else return $urandom_range(81, 200);
  endfunction

  function automatic logic [RD_ADDR_W-1:0] cursor_row_address();
    return RD_ADDR_W'(sb.row * COLS + $urandom_range(0, COLS - 1));
  endfunction

  // Mostly text lines of random length ended by a newline, mixed with reads;
  // clears and the unused action are rare so the screen fills and scrolls.
  task automatic random_item();
    int pick;
    byte_t code;
    logic [RD_ADDR_W-1:0] addr;
    pick = $urandom_range(0, 999);
    code = byte_t'($urandom_range(0, 255));
    addr = RD_ADDR_W'($urandom_range(0, 2047));
    if (pick < 3) begin
      send_item(ACT_CLEAR, code, addr);
    end else if (pick < 20) begin
      send_item(ACT_SPARE, code, addr);
    end else if (pick < 320) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) addr = RD_ADDR_W'($urandom_range(0, CELLS - 1));
      else if (pick < 90) addr = cursor_row_address();
      else addr = RD_ADDR_W'($urandom_range(CELLS, 2047));
      send_item(ACT_READ, code, addr);
    end else begin
      if (line_left == 0) begin
        code = NEWLINE_CODE;
        line_left = line_length();
      end else begin
        line_left--;
      end
      send_item(ACT_PUT, code, addr);
    end
  endtask

  task automatic directed_items();
    send_item(ACT_PUT, 8'h00, 11'd0);
    send_item(ACT_PUT, 8'hFF, 11'h7FF);
    send_item(ACT_PUT, 8'h41, 11'd0);
    send_item(ACT_PUT, 8'h0D, 11'd0);
    send_item(ACT_PUT, NEWLINE_CODE, 11'd0);
    send_item(ACT_PUT, 8'h7F, 11'd0);
    send_item(ACT_READ, 8'h00, 11'd0);
    send_item(ACT_READ, 8'hFF, 11'd1);
    send_item(ACT_READ, 8'h00, 11'd3);
    send_item(ACT_READ, 8'h00, 11'd80);
    send_item(ACT_READ, 8'h00, 11'd1999);
    send_item(ACT_READ, 8'h00, 11'd2000);
    send_item(ACT_READ, 8'h00, 11'd2047);
    send_item(ACT_READ, 8'h00, 11'd1024);
    send_item(ACT_SPARE, 8'hFF, 11'h7FF);
    send_item(ACT_CLEAR, 8'h00, 11'd0);
    send_item(ACT_READ, 8'h00, 11'd0);
    send_item(ACT_READ, 8'h00, 11'd81);
    send_item(ACT_PUT, 8'h80, 11'd0);
    send_item(ACT_PUT, NEWLINE_CODE, 11'd0);
    send_item(ACT_READ, 8'h00, 11'd0);
  endtask

  // Result side: random stalls, plus one long hold-off that backs up the input.
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && sb.checked >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(console_result_t'(out_tdata));
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("text_console_writer_unit_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    byte_t attr_plan [PHASES];
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = ACT_PUT;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    calm = 1'b0;
    line_left = 0;
    attr_plan = '{RESET_ATTR, 8'h00, 8'hFF, byte_t'($urandom_range(0, 255)), 8'h4E,
                  byte_t'($urandom_range(0, 255))};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < PHASES; phase++) begin
      // The first phase runs with the attribute left by reset.
      if (phase > 0) write_attribute(attr_plan[phase]);
      calm = (phase == 2);
      if (phase == 0) directed_items();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) random_item();
      // A closing read cannot finish before any earlier scroll has.
      send_item(ACT_READ, 8'h00, cursor_row_address());
      @(negedge clk);
      in_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clk);
    end

    repeat (20) @(posedge clk);
    $display("Run covered %0d puts (%0d newlines), %0d reads, %0d clears, %0d unused actions.",
             sb.puts, sb.newlines, sb.reads, sb.clears, sb.spares);
    $display("It saw %0d scrolls and %0d attribute writes; %0d results were checked.",
             sb.scrolls, sb.attr_writes, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("text_console_writer_unit_tb OK");
    end else begin
      $display("text_console_writer_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
design/tcw_pkg.sv
design/tcw_ram.sv
design/text_console_writer_unit.sv
verif/text_console_writer_unit_tb.sv
